FILE: design/trrs_pkg.sv
// ----------------------------------------------------------------------------
// Task table scheduler package
// Shared types, codes and sizes for the round-robin task table.
// ----------------------------------------------------------------------------
package trrs_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [2:0] MODE_CREATE  = 3'd0;
    localparam logic [2:0] MODE_EXIT    = 3'd1;
    localparam logic [2:0] MODE_YIELD   = 3'd2;
    localparam logic [2:0] MODE_BLOCK   = 3'd3;
    localparam logic [2:0] MODE_UNBLOCK = 3'd4;
    localparam logic [2:0] MODE_WAIT    = 3'd5;

    localparam logic [2:0] ST_FREE    = 3'd0;
    localparam logic [2:0] ST_READY   = 3'd1;
    localparam logic [2:0] ST_RUNNING = 3'd2;
    localparam logic [2:0] ST_BLOCKED = 3'd3;
    localparam logic [2:0] ST_ZOMBIE  = 3'd4;

    localparam logic [2:0] RES_OK        = 3'd0;
    localparam logic [2:0] RES_NO_SLOT   = 3'd1;
    localparam logic [2:0] RES_NOT_FOUND = 3'd2;
    localparam logic [2:0] RES_EXIT_ZERO = 3'd3;
    localparam logic [2:0] RES_CHILD_RUN = 3'd4;

    typedef struct packed {
        logic [2:0]         mode;
        logic [15:0]        target_id;
        logic signed [31:0] exit_value;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [15:0]        created_id;
        logic signed [31:0] child_exit_value;
        logic [15:0]        running_id;
        logic               switched;
    } rsp_t;

    // Scan kinds run by the datapath walker
    typedef enum logic [1:0] {
        SCAN_FREE   = 2'd0,
        SCAN_LOOKUP = 2'd1,
        SCAN_READY  = 2'd2
    } scan_t;

    // Controller to datapath
    typedef struct packed {
        logic  latch;       // capture command
        logic  scan_start;  // reset walker
        scan_t scan_kind;
        logic  scan_parent; // lookup key is parent of current slot
        logic  scan_step;   // examine one slot
        logic  do_create;
        logic  do_exit;
        logic  do_wake_parent;
        logic  do_block;
        logic  do_unblock;
        logic  do_reap;
        logic  do_self_block;
        logic  do_switch;
        logic  respond;
        logic [2:0] res;
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] mode;
        logic       scan_done;
        logic       found;
        logic       cur_exit_bad;
        logic       hit_zombie;
        logic       sched_on;
        logic       ready_other;
    } sts_t;

endpackage

FILE: design/trrs_datapath.sv
// ----------------------------------------------------------------------------
// Task table datapath
// Slot arrays, current slot, id counter and a one-slot-per-cycle walker.
// ----------------------------------------------------------------------------
module trrs_datapath
    import trrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  ctl_t ctl,
    output sts_t sts,
    output logic result_valid,
    output rsp_t result
);

    logic [15:0]       id_reg     [SLOTS];
    logic [2:0]        stat_reg   [SLOTS];
    logic [15:0]       parent_reg [SLOTS];
    logic [31:0]       code_reg   [SLOTS];
    logic [SLOT_W-1:0] cur_reg;
    logic [SLOT_W-1:0] before_reg;
    logic [15:0]       next_id_reg;
    logic              sched_reg;
    cmd_t              cmd_reg;

    logic [CNT_W-1:0]  cnt_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] hit_reg;
    logic [15:0]       key_reg;
    logic              valid_reg;
    rsp_t              result_reg;

    logic [SLOT_W-1:0] pos_inc;
    logic [SLOT_W-1:0] cur_inc;
    logic              match;

    always_comb
    begin
        if (pos_reg == SLOT_W'(SLOTS - 1))
            pos_inc = '0;
        else
            pos_inc = pos_reg + 1'b1;
        if (cur_reg == SLOT_W'(SLOTS - 1))
            cur_inc = '0;
        else
            cur_inc = cur_reg + 1'b1;
    end

    // Match test for the slot under the walker
    always_comb
    begin
        case (ctl.scan_kind)
            SCAN_FREE:   match = (stat_reg[pos_reg] == ST_FREE);
            SCAN_LOOKUP: match = (stat_reg[pos_reg] != ST_FREE) &&
                                 (id_reg[pos_reg] == key_reg);
            SCAN_READY:  match = (stat_reg[pos_reg] == ST_READY);
            default:     match = 1'b0;
        endcase
    end

    // Walker: first hit wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            pos_reg   <= '0;
            found_reg <= 1'b0;
            hit_reg   <= '0;
            key_reg   <= '0;
        end
        else if (ctl.scan_start)
        begin
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            if (ctl.scan_kind == SCAN_READY)
                pos_reg <= cur_inc;
            else
                pos_reg <= '0;
            key_reg <= ctl.scan_parent ? parent_reg[cur_reg] : cmd_reg.target_id;
        end
        else if (ctl.scan_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            pos_reg <= pos_inc;
            if (match && !found_reg)
            begin
                found_reg <= 1'b1;
                hit_reg   <= pos_reg;
            end
        end
    end

    // Slot state and scheduler registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                id_reg[i]     <= '0;
                stat_reg[i]   <= (i == 0) ? ST_RUNNING : ST_FREE;
                parent_reg[i] <= '0;
                code_reg[i]   <= '0;
            end
            cur_reg     <= '0;
            before_reg  <= '0;
            next_id_reg <= 16'd1;
            sched_reg   <= 1'b0;
            cmd_reg     <= '0;
        end
        else
        begin
            if (ctl.latch)
            begin
                cmd_reg    <= cmd;
                before_reg <= cur_reg;
            end
            if (ctl.do_create)
            begin
                id_reg[hit_reg]     <= next_id_reg;
                stat_reg[hit_reg]   <= ST_READY;
                parent_reg[hit_reg] <= id_reg[cur_reg];
                code_reg[hit_reg]   <= '0;
                next_id_reg         <= next_id_reg + 1'b1;
                sched_reg           <= 1'b1;
            end
            if (ctl.do_exit)
            begin
                stat_reg[cur_reg] <= ST_ZOMBIE;
                code_reg[cur_reg] <= cmd_reg.exit_value;
            end
            if (ctl.do_wake_parent && stat_reg[hit_reg] == ST_BLOCKED)
                stat_reg[hit_reg] <= ST_READY;
            if (ctl.do_block)
                stat_reg[hit_reg] <= ST_BLOCKED;
            if (ctl.do_unblock && stat_reg[hit_reg] == ST_BLOCKED)
                stat_reg[hit_reg] <= ST_READY;
            if (ctl.do_reap)
                stat_reg[hit_reg] <= ST_FREE;
            if (ctl.do_self_block && stat_reg[cur_reg] != ST_FREE)
                stat_reg[cur_reg] <= ST_BLOCKED;
            if (ctl.do_switch)
            begin
                if (stat_reg[cur_reg] == ST_RUNNING)
                    stat_reg[cur_reg] <= ST_READY;
                stat_reg[hit_reg] <= ST_RUNNING;
                cur_reg <= hit_reg;
            end
        end
    end

    // Result register, one strobe per command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= ctl.respond;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.respond)
        begin
            result_reg.status     <= ctl.res;
            result_reg.created_id <= (cmd_reg.mode == MODE_CREATE && ctl.res == RES_OK)
                                     ? (next_id_reg - 1'b1) : 16'd0;
            result_reg.child_exit_value <=
                (cmd_reg.mode == MODE_WAIT && ctl.res == RES_OK)
                ? $signed(code_reg[hit_reg]) : 32'sd0;
            result_reg.running_id <= id_reg[cur_reg];
            result_reg.switched   <= (cur_reg != before_reg);
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    assign sts.mode         = cmd_reg.mode;
    assign sts.scan_done    = (cnt_reg == CNT_W'(SLOTS));
    assign sts.found        = found_reg;
    assign sts.cur_exit_bad = (stat_reg[cur_reg] == ST_FREE) || (id_reg[cur_reg] == 16'd0);
    assign sts.hit_zombie   = (stat_reg[hit_reg] == ST_ZOMBIE);
    assign sts.sched_on     = sched_reg;
    assign sts.ready_other  = found_reg && (hit_reg != cur_reg);

`ifndef SYNTHESIS
    a_switch_moves: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.do_switch |=> stat_reg[cur_reg] == ST_RUNNING)
        else $error("switched slot not running");
    a_create_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.do_create |=> next_id_reg == $past(next_id_reg) + 16'd1)
        else $error("id counter did not advance");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(SLOTS))
        else $error("walker ran past table");
`endif

endmodule

FILE: design/trrs_ctrl.sv
// ----------------------------------------------------------------------------
// Task table controller
// Sequences scans and updates for one command at a time.
// ----------------------------------------------------------------------------
module trrs_ctrl
    import trrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  sts_t sts,
    output ctl_t ctl
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_DECODE = 8'b00000010,
        S_SCAN   = 8'b00000100,
        S_ACT    = 8'b00001000,
        S_PSCAN  = 8'b00010000,
        S_WAKE   = 8'b00100000,
        S_YSCAN  = 8'b01000000,
        S_YACT   = 8'b10000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= RES_OK;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        ctl        = '0;
        ctl.res    = res_reg;
        ctl.scan_kind = SCAN_LOOKUP;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch  = 1'b1;
                    res_next   = RES_OK;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctl.scan_start = 1'b1;
                case (sts.mode)
                    MODE_CREATE:
                    begin
                        ctl.scan_kind = SCAN_FREE;
                        state_next    = S_SCAN;
                    end
                    MODE_EXIT:
                    begin
                        if (sts.cur_exit_bad)
                        begin
                            ctl.respond = 1'b1;
                            ctl.res     = RES_EXIT_ZERO;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            ctl.do_exit     = 1'b1;
                            ctl.scan_parent = 1'b1;
                            state_next      = S_PSCAN;
                        end
                    end
                    MODE_YIELD:
                    begin
                        ctl.scan_kind = SCAN_READY;
                        state_next    = S_YSCAN;
                    end
                    MODE_BLOCK, MODE_UNBLOCK, MODE_WAIT:
                        state_next = S_SCAN;
                    default:
                    begin
                        ctl.respond = 1'b1;
                        state_next  = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                ctl.scan_kind = (sts.mode == MODE_CREATE) ? SCAN_FREE : SCAN_LOOKUP;
                if (sts.scan_done)
                    state_next = S_ACT;
                else
                    ctl.scan_step = 1'b1;
            end
            S_ACT:
            begin
                state_next = S_IDLE;
                if (!sts.found)
                begin
                    ctl.res = (sts.mode == MODE_CREATE) ? RES_NO_SLOT : RES_NOT_FOUND;
                    ctl.respond = 1'b1;
                end
                else
                begin
                    case (sts.mode)
                        MODE_CREATE:  ctl.do_create  = 1'b1;
                        MODE_BLOCK:   ctl.do_block   = 1'b1;
                        MODE_UNBLOCK: ctl.do_unblock = 1'b1;
                        MODE_WAIT:
                        begin
                            if (sts.hit_zombie)
                                ctl.do_reap = 1'b1;
                            else
                            begin
                                ctl.do_self_block = 1'b1;
                                res_next   = RES_CHILD_RUN;
                                state_next = S_YSCAN;
                            end
                        end
                        default: ;
                    endcase
                    // respond from S_YACT so state writes are seen
                    if (state_next == S_IDLE)
                        state_next = S_YACT;
                    if (sts.mode == MODE_WAIT && !sts.hit_zombie)
                    begin
                        ctl.scan_start = 1'b1;
                        ctl.scan_kind  = SCAN_READY;
                    end
                end
            end
            S_PSCAN:
            begin
                if (sts.scan_done)
                    state_next = S_WAKE;
                else
                    ctl.scan_step = 1'b1;
            end
            S_WAKE:
            begin
                if (sts.found)
                    ctl.do_wake_parent = 1'b1;
                ctl.scan_start = 1'b1;
                ctl.scan_kind  = SCAN_READY;
                state_next     = S_YSCAN;
            end
            S_YSCAN:
            begin
                ctl.scan_kind = SCAN_READY;
                if (sts.scan_done)
                begin
                    if (sts.sched_on && sts.ready_other)
                        ctl.do_switch = 1'b1;
                    state_next = S_YACT;
                end
                else
                    ctl.scan_step = 1'b1;
            end
            S_YACT:
            begin
                ctl.respond = 1'b1;
                state_next  = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> busy)
        else $error("accepted command did not raise busy");
    a_respond_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.respond |=> state_reg == S_IDLE)
        else $error("response not at end of command");
`endif

endmodule

FILE: design/task_table_round_robin_scheduler.sv
// ----------------------------------------------------------------------------
// Round-robin task table scheduler
// Task slots with create, exit, yield, block, unblock and wait commands.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd and raise start; the command is taken at a clock edge where
//   busy is low. busy stays high until the result is shown.
//   One result per command appears on result for a single cycle, marked by
//   result_valid; the receiver must take it then and cannot stall.
// Timing:
//   Each command that walks the slot table steps one slot per cycle in the
//   datapath; a refused exit or an unused mode makes no walk. Exit makes
//   two walks (parent lookup, ready search); wait on a running child makes
//   two (lookup, ready search). The next command can be taken at the
//   result edge.
// Reset:
//   Slot 0 holds the running task with id 0, the others are free, the next
//   id is 1 and scheduling is off until the first create.
// ----------------------------------------------------------------------------
module task_table_round_robin_scheduler
    import trrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic result_valid,
    output rsp_t result
);

    ctl_t ctl;
    sts_t sts;

    trrs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    trrs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .ctl          (ctl),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Task table scheduler testbench
// Drives scheduler commands from a queue, predicts each response with a
// local model of the task table and compares every response field by field.
// ----------------------------------------------------------------------------
module testbench;
    import trrs_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic result_valid;
    rsp_t result;

    task_table_round_robin_scheduler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    // Model of the task table
    logic [15:0] tbl_id [SLOTS];
    logic [2:0]  tbl_state [SLOTS];
    logic [15:0] tbl_parent [SLOTS];
    logic [31:0] tbl_code [SLOTS];
    int          cur_slot;
    logic [15:0] id_counter;
    logic        sched_enabled;

    cmd_t cmd_queue[$];
    rsp_t rsp_expected[$];
    int   error_count;
    bit   calm;
    bit   hold_off;

    always #4 clk = ~clk;

    task automatic table_reset();
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_id[i] = '0;
            tbl_state[i] = ST_FREE;
            tbl_parent[i] = '0;
            tbl_code[i] = '0;
        end
        tbl_state[0] = ST_RUNNING;
        cur_slot = 0;
        id_counter = 16'd1;
        sched_enabled = 1'b0;
    endtask

    function automatic int find_task(logic [15:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_state[i] != ST_FREE && tbl_id[i] == key)
                return i;
        return -1;
    endfunction

    task automatic reschedule();
        int pick;
        int idx;
        pick = -1;
        if (!sched_enabled)
            return;
        for (int i = 0; i < SLOTS; i++)
        begin
            idx = (cur_slot + 1 + i) % SLOTS;
            if (tbl_state[idx] == ST_READY)
            begin
                pick = idx;
                break;
            end
        end
        if (pick < 0 || pick == cur_slot)
            return;
        if (tbl_state[cur_slot] == ST_RUNNING)
            tbl_state[cur_slot] = ST_READY;
        tbl_state[pick] = ST_RUNNING;
        cur_slot = pick;
    endtask

    // Apply one command to the table and return the response it gives
    task automatic apply_command(input cmd_t c, output rsp_t r);
        int s;
        int prior;
        prior = cur_slot;
        r = '0;
        case (c.mode)
            MODE_CREATE:
            begin
                s = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_state[i] == ST_FREE)
                    begin
                        s = i;
                        break;
                    end
                if (s < 0)
                    r.status = RES_NO_SLOT;
                else
                begin
                    tbl_id[s] = id_counter;
                    tbl_state[s] = ST_READY;
                    tbl_parent[s] = tbl_id[cur_slot];
                    tbl_code[s] = '0;
                    r.created_id = id_counter;
                    id_counter = id_counter + 16'd1;
                    sched_enabled = 1'b1;
                end
            end
            MODE_EXIT:
            begin
                if (tbl_state[cur_slot] == ST_FREE || tbl_id[cur_slot] == 16'd0)
                    r.status = RES_EXIT_ZERO;
                else
                begin
                    tbl_state[cur_slot] = ST_ZOMBIE;
                    tbl_code[cur_slot] = c.exit_value;
                    s = find_task(tbl_parent[cur_slot]);
                    if (s >= 0 && tbl_state[s] == ST_BLOCKED)
                        tbl_state[s] = ST_READY;
                    reschedule();
                end
            end
            MODE_YIELD:
                reschedule();
            MODE_BLOCK:
            begin
                s = find_task(c.target_id);
                if (s < 0)
                    r.status = RES_NOT_FOUND;
                else
                    tbl_state[s] = ST_BLOCKED;
            end
            MODE_UNBLOCK:
            begin
                s = find_task(c.target_id);
                if (s < 0)
                    r.status = RES_NOT_FOUND;
                else if (tbl_state[s] == ST_BLOCKED)
                    tbl_state[s] = ST_READY;
            end
            MODE_WAIT:
            begin
                s = find_task(c.target_id);
                if (s < 0)
                    r.status = RES_NOT_FOUND;
                else if (tbl_state[s] == ST_ZOMBIE)
                begin
                    r.child_exit_value = tbl_code[s];
                    tbl_state[s] = ST_FREE;
                end
                else
                begin
                    if (tbl_state[cur_slot] != ST_FREE)
                        tbl_state[cur_slot] = ST_BLOCKED;
                    reschedule();
                    r.status = RES_CHILD_RUN;
                end
            end
            default:
                ;
        endcase
        r.running_id = tbl_id[cur_slot];
        r.switched = (cur_slot != prior);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Pick an id that is mostly live, sometimes arbitrary
    function automatic logic [15:0] pick_target();
        int n;
        n = $urandom_range(0, 9);
        if (n < 7)
            return tbl_id[$urandom_range(0, SLOTS - 1)];
        if (n < 9)
            return id_counter - 16'($urandom_range(1, 20));
        return 16'($urandom);
    endfunction

    function automatic cmd_t make_cmd(logic [2:0] m, logic [15:0] t, logic [31:0] v);
        cmd_t c;
        c.mode = m;
        c.target_id = t;
        c.exit_value = v;
        return c;
    endfunction

    // Driver: hold start with the pending command, advance on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
        end
        else
        begin
            if (start && !busy)
                void'(cmd_queue.pop_front());
            if (!(start && !busy) && start)
                ;
            else if (cmd_queue.size() > (start && !busy ? 0 : 0) && !hold_off
                     && (calm || $urandom_range(0, 99) >= 34))
            begin
                start <= 1'b1;
                cmd <= cmd_queue[0];
            end
            else
                start <= 1'b0;
        end
    end

    // Predict at acceptance
    always @(posedge clk)
    begin
        rsp_t r;
        if (rst_n && start && !busy)
        begin
            apply_command(cmd, r);
            rsp_expected.push_back(r);
        end
    end

    // Monitor: compare each response with the oldest prediction
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && result_valid)
        begin
            if (rsp_expected.size() == 0)
                report_mismatch("unexpected response", 32'(result.status), 32'd0);
            else
            begin
                want = rsp_expected.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", result.status, want.status);
                if (result.created_id !== want.created_id)
                    report_mismatch("created_id", result.created_id, want.created_id);
                if (result.child_exit_value !== want.child_exit_value)
                    report_mismatch("child_exit_value", result.child_exit_value,
                                    want.child_exit_value);
                if (result.running_id !== want.running_id)
                    report_mismatch("running_id", result.running_id, want.running_id);
                if (result.switched !== want.switched)
                    report_mismatch("switched", result.switched, want.switched);
            end
        end
    end

    // Stimulus
    initial
    begin
        int m;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        error_count = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        table_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: idle-table commands and refusals, then fill, overflow and churn
        cmd_queue.push_back(make_cmd(MODE_YIELD, 16'd0, 32'd0));
        cmd_queue.push_back(make_cmd(MODE_EXIT, 16'd0, 32'd5));
        cmd_queue.push_back(make_cmd(MODE_BLOCK, 16'hFFFF, 32'd0));
        cmd_queue.push_back(make_cmd(MODE_UNBLOCK, 16'd0, 32'd0));
        cmd_queue.push_back(make_cmd(3'd6, 16'hFFFF, 32'hFFFFFFFF));
        cmd_queue.push_back(make_cmd(3'd7, 16'd0, 32'd0));
        for (int i = 0; i < 16; i++)
            cmd_queue.push_back(make_cmd(MODE_CREATE, 16'd0, 32'd0));
        cmd_queue.push_back(make_cmd(MODE_YIELD, 16'd0, 32'd0));
        cmd_queue.push_back(make_cmd(MODE_WAIT, 16'd0, 32'd0));
        cmd_queue.push_back(make_cmd(MODE_UNBLOCK, 16'd0, 32'd0));
        cmd_queue.push_back(make_cmd(MODE_EXIT, 16'd0, 32'h80000000));
        cmd_queue.push_back(make_cmd(MODE_YIELD, 16'd0, 32'd0));
        cmd_queue.push_back(make_cmd(MODE_EXIT, 16'd0, 32'h7FFFFFFF));
        cmd_queue.push_back(make_cmd(MODE_WAIT, 16'd1, 32'd0));
        cmd_queue.push_back(make_cmd(MODE_WAIT, 16'd2, 32'd0));
        cmd_queue.push_back(make_cmd(MODE_BLOCK, 16'd3, 32'd0));

        // Pause the sender until every prediction has been answered
        wait (cmd_queue.size() == 0);
        hold_off = 1'b1;
        @(posedge clk);
        wait (rsp_expected.size() == 0);
        @(posedge clk);
        hold_off = 1'b0;

        // Random: weighted towards create, exit and wait with live ids
        for (int n = 0; n < 1030; n++)
        begin
            if (n == 300)
                calm = 1'b1;
            if (n == 450)
                calm = 1'b0;
            m = $urandom_range(0, 99);
            if (m < 22)
                cmd_queue.push_back(make_cmd(MODE_CREATE, 16'($urandom), $urandom));
            else if (m < 40)
                cmd_queue.push_back(make_cmd(MODE_EXIT, 16'($urandom), $urandom));
            else if (m < 55)
                cmd_queue.push_back(make_cmd(MODE_YIELD, 16'($urandom), $urandom));
            else if (m < 63)
                cmd_queue.push_back(make_cmd(MODE_BLOCK, 16'($urandom), $urandom));
            else if (m < 75)
                cmd_queue.push_back(make_cmd(MODE_UNBLOCK, 16'($urandom), $urandom));
            else if (m < 97)
                cmd_queue.push_back(make_cmd(MODE_WAIT, 16'($urandom), $urandom));
            else
                cmd_queue.push_back(make_cmd(3'($urandom_range(6, 7)), 16'($urandom),
                                             $urandom));
            // Targets use live ids; fill in when the predictor state is current
            wait (cmd_queue.size() < 2);
            if (cmd_queue[cmd_queue.size() - 1].mode inside {MODE_BLOCK, MODE_UNBLOCK,
                                                             MODE_WAIT})
                cmd_queue[cmd_queue.size() - 1].target_id = pick_target();
        end

        wait (cmd_queue.size() == 0);
        @(posedge clk);
        wait (rsp_expected.size() == 0);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
